// ===== rtl/accuracy_threshold_sweep_top_assert.svh =====
// assertion macros for the accuracy threshold sweep
`ifndef ACCURACY_THRESHOLD_SWEEP_TOP_ASSERT_SVH
`define ACCURACY_THRESHOLD_SWEEP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ATS_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("label");
`define ATS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("label");
`else
`define ATS_ASSERT_IMPLIES(label, clk, rst, a, b)
`define ATS_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/ats_pkg.sv =====
// shared types and constants for the accuracy threshold sweep
package ats_pkg;
  localparam int TableDepth = 256;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = IdxW + 1;
  localparam int ProbW = 17;
  localparam int WtW = 16;
  localparam int NetW = 32;
  localparam int TotW = 40;
  localparam int AccW = 17;
  localparam logic [ProbW-1:0] HalfQ16 = 17'd32768;
  localparam logic [ProbW-1:0] OneQ16 = 17'd65536;
  localparam logic [TotW-1:0] TotMax = {TotW{1'b1}};
  localparam logic OpAdd = 1'b0;
  localparam logic OpFinish = 1'b1;

  typedef struct packed {
    logic search_start; // load item and start scan
    logic search_step;  // compare one entry
    logic shift_step;   // move one entry up
    logic write_new;    // store the new key
    logic write_merge;  // update an existing entry
    logic drop;         // full table
    logic sweep_start;
    logic sweep_step;
    logic div_start;
    logic div_step;
    logic out_load;
    logic clear;
  } ats_cmd_t;

  typedef struct packed {
    logic search_done;
    logic found;
    logic full;
    logic shift_done;
    logic few;
    logic sweep_done;
    logic div_done;
  } ats_status_t;
endpackage

// ===== rtl/ats_datapath.sv =====
// table memory, insertion shifter, sweep and divider datapath
module ats_datapath (
  input  logic clk,
  input  logic rst,
  input  ats_pkg::ats_cmd_t cmd,
  output ats_pkg::ats_status_t status,
  input  logic [ats_pkg::ProbW-1:0] in_prob,
  input  logic [ats_pkg::WtW-1:0] in_weight,
  input  logic in_target,
  output logic [ats_pkg::ProbW-1:0] res_threshold,
  output logic [ats_pkg::AccW-1:0] res_accuracy,
  output logic res_few,
  output logic res_overflow
);
  localparam int IdxW = ats_pkg::IdxW;
  localparam int CntW = ats_pkg::CntW;
  localparam int ProbW = ats_pkg::ProbW;
  localparam int NetW = ats_pkg::NetW;
  localparam int TotW = ats_pkg::TotW;
  localparam int WtW_L = ats_pkg::WtW;

  logic [ProbW+NetW-1:0] mem [ats_pkg::TableDepth];
  logic [ProbW+NetW-1:0] rd;
  logic [IdxW-1:0] rd_addr;
  logic [ProbW+NetW-1:0] wr_data;
  logic [IdxW-1:0] wr_addr;
  logic wr_en;

  logic [CntW-1:0] entry_count;
  logic [TotW-1:0] total_weight, target_weight;
  logic overflow_seen;
  logic [ProbW-1:0] key;
  logic [WtW_L-1:0] wt;
  logic tgt;
  logic [CntW-1:0] ptr;
  logic [CntW-1:0] pos;
  logic rd_ok;

  logic signed [NetW:0] net_sum;
  logic signed [NetW-1:0] net_sat;
  logic signed [NetW-1:0] signed_w;
  logic signed [TotW+1:0] corr, best;
  logic [ProbW-1:0] prev_key, thr;
  logic chosen, sweep_first;
  logic [TotW+16:0] rem;
  logic [TotW+16:0] num;
  logic [5:0] div_cnt;
  logic [16:0] quo;
  logic quo_ovf;
  logic [TotW+16:0] div_rem_next;
  logic [TotW:0] tot_add, tgt_add;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd <= mem[rd_addr];
  end

  assign signed_w = tgt ? -NetW'(signed'({1'b0, wt})) : NetW'(signed'({1'b0, wt}));
  assign net_sum = (cmd.write_merge ? (NetW+1)'(signed'(rd[NetW-1:0])) : '0)
                 + (NetW+1)'(signed_w);
  always_comb begin
    if (net_sum > (NetW+1)'(signed'(32'h7fffffff))) begin
      net_sat = 32'sh7fffffff;
    end else if (net_sum < -(NetW+1)'(signed'(33'sh080000000))) begin
      net_sat = 32'sh80000000;
    end else begin
      net_sat = net_sum[NetW-1:0];
    end
  end

  // read address: scan pointer during search and sweep, source of shift
  always_comb begin
    rd_addr = ptr[IdxW-1:0];
    wr_en = 1'b0;
    wr_addr = pos[IdxW-1:0];
    wr_data = {key, net_sat};
    if (cmd.shift_step) begin
      wr_en = 1'b1;
      wr_addr = ptr[IdxW-1:0];
      wr_data = rd;
      rd_addr = IdxW'(ptr - CntW'(2));
    end else if (cmd.write_new || cmd.write_merge) begin
      wr_en = 1'b1;
    end else if (cmd.search_step && status.search_done) begin
      // fetch the entry to merge into, or the top entry that moves first
      rd_addr = status.found ? IdxW'(ptr - CntW'(1)) : IdxW'(entry_count - CntW'(1));
    end
  end

  assign rd_ok = ptr != '0;
  assign status.full = entry_count == CntW'(ats_pkg::TableDepth);
  assign status.few = entry_count < CntW'(2);
  assign status.search_done = rd_ok && (ptr > entry_count || rd[ProbW+NetW-1:NetW] >= key);
  assign status.found = ptr <= entry_count && rd[ProbW+NetW-1:NetW] == key;
  assign status.shift_done = ptr == pos;
  assign status.sweep_done = ptr == entry_count + CntW'(1);
  assign status.div_done = div_cnt == 6'd0;

  assign tot_add = {1'b0, total_weight} + (TotW+1)'(wt);
  assign tgt_add = {1'b0, target_weight} + (TotW+1)'(wt);
  assign div_rem_next = {rem[TotW+15:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      entry_count <= '0;
      total_weight <= '0;
      target_weight <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.drop) begin
        overflow_seen <= 1'b1;
      end
      if (cmd.write_new || cmd.write_merge) begin
        total_weight <= tot_add[TotW] ? ats_pkg::TotMax : tot_add[TotW-1:0];
        if (tgt) begin
          target_weight <= tgt_add[TotW] ? ats_pkg::TotMax : tgt_add[TotW-1:0];
        end
      end
      if (cmd.write_new) begin
        entry_count <= entry_count + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      key <= in_prob;
      wt <= in_weight;
      tgt <= in_target;
      ptr <= '0;
    end else if (cmd.search_step) begin
      // ptr counts entries read plus one: the read for ptr lands next cycle
      if (status.search_done) begin
        pos <= ptr - CntW'(1);
        ptr <= entry_count;
      end else begin
        ptr <= ptr + CntW'(1);
      end
    end else if (cmd.shift_step) begin
      ptr <= ptr - CntW'(1);
    end else if (cmd.sweep_start) begin
      ptr <= '0;
      corr <= (TotW+2)'(signed'({1'b0, target_weight}));
      best <= '0;
      chosen <= 1'b0;
      thr <= ats_pkg::HalfQ16;
      sweep_first <= 1'b1;
    end else if (cmd.sweep_step) begin
      ptr <= ptr + CntW'(1);
      if (rd_ok) begin
        prev_key <= rd[ProbW+NetW-1:NetW];
        sweep_first <= 1'b0;
        if (!sweep_first) begin
          if (corr > best || (corr == best && prev_key < ats_pkg::HalfQ16)) begin
            best <= corr;
            thr <= ProbW'(({1'b0, prev_key} + {1'b0, rd[ProbW+NetW-1:NetW]}) >> 1);
            chosen <= 1'b1;
          end
        end
        if (ptr < entry_count) begin
          corr <= corr + (TotW+2)'(signed'(rd[NetW-1:0]));
        end
      end
    end else if (cmd.div_start) begin
      num <= {best[TotW:0], 16'd0};
      rem <= '0;
      quo <= '0;
      quo_ovf <= 1'b0;
      div_cnt <= 6'(TotW + 17);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - 6'd1;
      num <= {num[TotW+15:0], 1'b0};
      // a quotient bit leaving the top means the ratio is above range
      quo_ovf <= quo_ovf | quo[16];
      if ({div_rem_next[TotW+16:1], num[TotW+16]} >= (TotW+17)'(total_weight)) begin
        rem <= {div_rem_next[TotW+16:1], num[TotW+16]} - (TotW+17)'(total_weight);
        quo <= 17'({quo[15:0], 1'b1});
      end else begin
        rem <= {div_rem_next[TotW+16:1], num[TotW+16]};
        quo <= 17'({quo[15:0], 1'b0});
      end
    end
  end

  // the sweep looks at the pair (prev_key, key) once the next key is read;
  // corr already includes prev entry's net weight when comparing
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_few <= status.few;
      res_overflow <= overflow_seen;
      if (status.few || !chosen) begin
        res_threshold <= ats_pkg::HalfQ16;
        res_accuracy <= '0;
      end else begin
        res_threshold <= thr;
        if (total_weight == '0 || best <= 0) begin
          res_accuracy <= '0;
        end else if (quo > ats_pkg::OneQ16 || quo_ovf) begin
          res_accuracy <= ats_pkg::OneQ16;
        end else begin
          res_accuracy <= quo;
        end
      end
    end
  end
endmodule

// ===== rtl/ats_ctrl.sv =====
// sequencer for insert, sweep, divide and report
module ats_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  input  logic item_op,
  input  logic item_missing,
  output logic item_ready,
  output logic res_valid,
  input  logic res_ready,
  output ats_pkg::ats_cmd_t cmd,
  input  ats_pkg::ats_status_t status
);
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b00000001,
    ST_SEARCH = 8'b00000010,
    ST_SHIFT  = 8'b00000100,
    ST_WRITE  = 8'b00001000,
    ST_SWEEP  = 8'b00010000,
    ST_DIV    = 8'b00100000,
    ST_REPORT = 8'b01000000,
    ST_HOLD   = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic merge, merge_next;
  logic accept;

  assign item_ready = state == ST_IDLE;
  assign accept = item_valid && item_ready;
  assign res_valid = state == ST_HOLD;

  always_comb begin
    state_next = state;
    merge_next = merge;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item_op == ats_pkg::OpFinish) begin
            cmd.sweep_start = 1'b1;
            state_next = ST_SWEEP;
          end else if (!item_missing) begin
            cmd.search_start = 1'b1;
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.search_done) begin
          if (status.found) begin
            merge_next = 1'b1;
            state_next = ST_WRITE;
          end else if (status.full) begin
            cmd.drop = 1'b1;
            state_next = ST_IDLE;
          end else begin
            merge_next = 1'b0;
            state_next = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (status.shift_done) begin
          state_next = ST_WRITE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      ST_WRITE: begin
        cmd.write_merge = merge;
        cmd.write_new = !merge;
        state_next = ST_IDLE;
      end
      ST_SWEEP: begin
        if (status.sweep_done) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_REPORT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_REPORT: begin
        cmd.out_load = 1'b1;
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (res_ready) begin
          cmd.clear = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      merge <= 1'b0;
    end else begin
      state <= state_next;
      merge <= merge_next;
    end
  end
endmodule

// ===== rtl/accuracy_threshold_sweep_top.sv =====
// top level of the accuracy threshold sweep
// channel | dir | tdata fields (lsb first)                     | tuser
// s_axis  | in  | prob[16:0] weight[32:17] is_target[33] miss[34] | operation
// m_axis  | out | threshold[16:0] accuracy[33:17] too_few[34] ovf[35] | none
// an add transaction holds the input while p entries below the insert point are scanned and
// s entries shifted, one at a time on the single table port (no shift on a key already
// present, no shift or write when dropped)
// finish runs the sweep over the table, the divider and a load step, then the result waits
// reset is synchronous and empties the table; no clearing pass is needed
// input is stalled while an item is in work or a result is not yet taken
`include "accuracy_threshold_sweep_top_assert.svh"
module accuracy_threshold_sweep_top (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // prob, weight, is_target, class_missing
  input  logic s_axis_tuser,         // operation
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [39:0] m_axis_tdata   // threshold, accuracy, too_few_values, table_overflow
);
  ats_pkg::ats_cmd_t cmd;
  ats_pkg::ats_status_t status;
  logic [ats_pkg::ProbW-1:0] prob_sat, thr;
  logic [ats_pkg::AccW-1:0] acc;
  logic few, ovf;
  logic s_take;

  // probabilities above one saturate
  assign prob_sat = s_axis_tdata[16:0] > ats_pkg::OneQ16 ? ats_pkg::OneQ16 : s_axis_tdata[16:0];

  // input transaction taken this cycle
  assign s_take = s_axis_tvalid && s_axis_tready;

  ats_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .item_valid(s_axis_tvalid), .item_op(s_axis_tuser), .item_missing(s_axis_tdata[34]),
    .item_ready(s_axis_tready), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .cmd(cmd), .status(status)
  );

  ats_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_prob(prob_sat), .in_weight(s_axis_tdata[32:17]), .in_target(s_axis_tdata[33]),
    .res_threshold(thr), .res_accuracy(acc), .res_few(few), .res_overflow(ovf)
  );

  assign m_axis_tdata = {4'd0, ovf, few, acc, thr};

  // no new transaction is taken while a result waits
  `ATS_ASSERT_IMPLIES(a_no_accept_hold, clk, rst, m_axis_tvalid, !s_axis_tready)
  // a finish transaction always starts the sweep
  `ATS_ASSERT_IMPLIES(a_finish_sweep, clk, rst, s_take && s_axis_tuser, cmd.sweep_start)
  // a taken result clears the table and drops the output valid
  `ATS_ASSERT_NEXT(a_clear_after, clk, rst, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)
endmodule
